/* hw/rtl/idq_pkg.sv */
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and constants for the indexed deque store: request and
// response transactions, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int Capacity = 64;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = 7;
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int DataW    = 32;

  typedef enum logic [3:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_PUSH_FRONT = 4'd1,
    FN_POP_FRONT  = 4'd2,
    FN_POP_BACK   = 4'd3,
    FN_PEEK_FRONT = 4'd4,
    FN_PEEK_BACK  = 4'd5,
    FN_READ       = 4'd6,
    FN_INSERT     = 4'd7,
    FN_REMOVE     = 4'd8,
    FN_CLEAR      = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [3:0]              func;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
    logic [6:0]              element_count;
    logic                    is_empty;
  } rsp_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e          op;
    logic [CmpW-1:0]   pos;
    logic [DataW-1:0]  value;
    logic [CmpW-1:0]   rd_pos;
  } cell_ctrl_t;

endpackage

/* hw/rtl/idq_cell.sv */
// ----------------------------------------------------------------------------
// idq_cell
// One storage cell of the shifting row. Holds one word, takes its left
// neighbor on insert, its right neighbor on remove, and drives its word
// onto the read bus when its index is selected.
// ----------------------------------------------------------------------------
module idq_cell (
  input  logic                        clk_i,
  input  logic [idq_pkg::IdxW-1:0]    idx_i,
  input  idq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [idq_pkg::DataW-1:0]   left_i,
  input  logic [idq_pkg::DataW-1:0]   right_i,
  output logic [idq_pkg::DataW-1:0]   data_o,
  output logic [idq_pkg::DataW-1:0]   rd_o
);
  import idq_pkg::*;

  logic [DataW-1:0] data_d, data_q;
  logic [CmpW-1:0]  idx_ext;

  assign idx_ext = CmpW'(idx_i);

  // Select shift source by position relative to this cell
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (idx_ext == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (idx_ext > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (idx_ext >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (idx_ext == ctrl_i.rd_pos) ? data_q : '0;

endmodule

/* hw/rtl/indexed_deque_store_top.sv */
// ----------------------------------------------------------------------------
// indexed_deque_store_top
// Bounded ordered store of signed words with deque and indexed access.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction in the cycle
// after it is accepted. The words live in a row of Capacity cells that shift
// toward the back on insert and toward the front on remove, all in the cycle
// the request is accepted, so one request per cycle is taken as long as the
// response register is drained. The read port is a one-hot select across the
// cells of the current contents; read and remove see the word before the
// shift. A full store answers push and insert with a full status, an index
// past the end with an out-of-range status. Unused function codes do nothing.
module indexed_deque_store_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  idq_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output idq_pkg::rsp_t  out_rsp_o
);
  import idq_pkg::*;

  logic            accept;
  logic [CntW-1:0] count_d, count_q;
  logic            out_valid_d, out_valid_q;
  rsp_t            rsp_d, rsp_q;
  cell_ctrl_t      ctrl;
  logic [CmpW-1:0] cnt_ext, pos_ext, last_ext;
  logic            use_read;
  status_e         status;
  logic [DataW-1:0] rd_word;

  logic [DataW-1:0] cell_data [Capacity];
  logic [DataW-1:0] cell_rd   [Capacity];

  // Take a new request whenever the response register is free or leaving
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign cnt_ext  = CmpW'(count_q);
  assign pos_ext  = CmpW'(in_req_i.position);
  assign last_ext = cnt_ext - CmpW'(1);

  // Decode request into cell control, status and next count
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.pos    = '0;
    ctrl.value  = in_req_i.item_value;
    ctrl.rd_pos = '0;
    use_read    = 1'b0;
    status      = ST_OK;
    count_d     = count_q;
    case (func_e'(in_req_i.func))
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
        if (func_e'(in_req_i.func) == FN_PUSH_BACK) begin
          ctrl.pos = cnt_ext;
        end else if (func_e'(in_req_i.func) == FN_INSERT) begin
          ctrl.pos = pos_ext;
        end
        if (ctrl.pos > cnt_ext) begin
          status = ST_RANGE;
        end else if (cnt_ext >= CmpW'(Capacity)) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_REMOVE: begin
        if (func_e'(in_req_i.func) == FN_POP_BACK) begin
          ctrl.pos = last_ext;
        end else if (func_e'(in_req_i.func) == FN_REMOVE) begin
          ctrl.pos = pos_ext;
        end
        ctrl.rd_pos = ctrl.pos;
        if (count_q == '0 || ctrl.pos >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctrl.op  = CELL_REMOVE;
          use_read = 1'b1;
          count_d  = count_q - CntW'(1);
        end
      end
      FN_PEEK_FRONT, FN_PEEK_BACK, FN_READ: begin
        if (func_e'(in_req_i.func) == FN_PEEK_BACK) begin
          ctrl.rd_pos = last_ext;
        end else if (func_e'(in_req_i.func) == FN_READ) begin
          ctrl.rd_pos = pos_ext;
        end
        if (count_q == '0 || ctrl.rd_pos >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          use_read = 1'b1;
        end
      end
      FN_CLEAR: count_d = '0;
      default:  count_d = count_q;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  // Build the row of cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    idq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Merge the one-hot read bus
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < Capacity; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Form the response and hold it while stalled
  always_comb begin
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (accept) begin
      out_valid_d         = 1'b1;
      rsp_d.read_value    = use_read ? rd_word : '0;
      rsp_d.status        = status;
      rsp_d.element_count = 7'(count_d);
      rsp_d.is_empty      = (count_d == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* dv/idq_store_checker.sv */
// ----------------------------------------------------------------------------
// idq_store_checker
// Watches both channels of the indexed deque store, keeps a shadow copy of
// the stored words, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module idq_store_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  idq_pkg::req_t in_req_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  idq_pkg::rsp_t out_rsp_i,
  output int            fail_count_o,
  output int            checked_o,
  output int            full_hits_o,
  output int            range_hits_o,
  output int            pending_o,
  output int            occupancy_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import idq_pkg::*;

  // Shadow of the cell row: words [0, shadow_count) are live
  logic [DataW-1:0] shadow_words [Capacity];
  int               shadow_count = 0;
  rsp_t             deque_rsps_due [$];

  int fails      = 0;
  int checked    = 0;
  int full_hits  = 0;
  int range_hits = 0;

  // Open a gap at pos and drop the word in; range is checked before fullness
  function automatic status_e insert_word(input int pos, input logic [DataW-1:0] w);
    if (pos > shadow_count) return ST_RANGE;
    if (shadow_count >= Capacity) return ST_FULL;
    for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = w;
    shadow_count++;
    return ST_OK;
  endfunction

  // Take the word at pos and close the gap behind it
  function automatic status_e remove_word(input int pos, output logic [DataW-1:0] w);
    w = '0;
    if (pos >= shadow_count) return ST_RANGE;
    w = shadow_words[pos];
    for (int i = pos; i < shadow_count - 1; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return ST_OK;
  endfunction

  function automatic status_e peek_word(input int pos, output logic [DataW-1:0] w);
    w = '0;
    if (pos >= shadow_count) return ST_RANGE;
    w = shadow_words[pos];
    return ST_OK;
  endfunction

  // Apply one request to the shadow row and build the response it earns
  function automatic rsp_t predict_deque_rsp(input req_t rq);
    rsp_t             rs;
    status_e          st;
    logic [DataW-1:0] w;
    st = ST_OK;
    w  = '0;
    case (rq.func)
      FN_PUSH_BACK:  st = insert_word(shadow_count, rq.item_value);
      FN_PUSH_FRONT: st = insert_word(0, rq.item_value);
      FN_POP_FRONT:  st = remove_word(0, w);
      FN_POP_BACK: begin
        if (shadow_count == 0) st = ST_RANGE;
        else st = remove_word(shadow_count - 1, w);
      end
      FN_PEEK_FRONT: st = peek_word(0, w);
      FN_PEEK_BACK: begin
        if (shadow_count == 0) st = ST_RANGE;
        else st = peek_word(shadow_count - 1, w);
      end
      FN_READ:       st = peek_word(int'(rq.position), w);
      FN_INSERT:     st = insert_word(int'(rq.position), rq.item_value);
      FN_REMOVE:     st = remove_word(int'(rq.position), w);
      FN_CLEAR:      shadow_count = 0;
      default: ;
    endcase
    if (st != ST_OK) w = '0;
    rs.read_value    = w;
    rs.status        = st;
    rs.element_count = 7'(shadow_count);
    rs.is_empty      = (shadow_count == 0);
    return rs;
  endfunction

  // Count a failure; print only the first few in full
  task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t: response %0d %s: expected value %h status %0d count %0d empty %b,",
               $realtime, checked, what, want.read_value, want.status,
               want.element_count, want.is_empty);
      $display("    got value %h status %0d count %0d empty %b",
               got.read_value, got.status, got.element_count, got.is_empty);
    end
  endtask

  // Check the response first: it belongs to a request taken at an earlier edge
  always @(posedge clk_i) begin
    rsp_t  want;
    string bad;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (out_rsp_i.status == ST_FULL) full_hits++;
        if (out_rsp_i.status == ST_RANGE) range_hits++;
        if (deque_rsps_due.size() == 0) begin
          flag_mismatch("with no request outstanding", '0, out_rsp_i);
        end else begin
          want = deque_rsps_due.pop_front();
          bad  = "";
          if (out_rsp_i.read_value !== want.read_value) bad = {bad, " read_value"};
          if (out_rsp_i.status !== want.status) bad = {bad, " status"};
          if (out_rsp_i.element_count !== want.element_count) bad = {bad, " element_count"};
          if (out_rsp_i.is_empty !== want.is_empty) bad = {bad, " is_empty"};
          if (bad != "") flag_mismatch({"wrong", bad}, want, out_rsp_i);
        end
      end
      if (in_valid_i && !in_stall_i) deque_rsps_due.push_back(predict_deque_rsp(in_req_i));
    end
    fail_count_o <= fails;
    checked_o    <= checked;
    full_hits_o  <= full_hits;
    range_hits_o <= range_hits;
    pending_o    <= deque_rsps_due.size();
    occupancy_o  <= shadow_count;
  end

endmodule

/* dv/tb_indexed_deque_store_top.sv */
// ----------------------------------------------------------------------------
// tb_indexed_deque_store_top
// Drives deque and indexed requests into the store through four idle and
// stall phases; a checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_indexed_deque_store_top;
  timeunit 1ns;
  timeprecision 1ps;
  import idq_pkg::*;

  localparam int         ClkHalf      = 5;
  localparam int         ResetCycles  = 12;
  localparam int         CycleLimit   = 200000;
  localparam int         PhaseItems   = 245;
  localparam logic [3:0] FnUnusedLow  = 4'd10;
  localparam logic [3:0] FnUnusedHigh = 4'd15;

  typedef enum int { MIX_OPS, GROW_OPS, SHRINK_OPS } op_mix_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  int fail_count;
  int checked;
  int full_hits;
  int range_hits;
  int pending_rsps;
  int occ_hint;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int cycle_count = 0;

  indexed_deque_store_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  idq_store_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .fail_count_o(fail_count),
    .checked_o   (checked),
    .full_hits_o (full_hits),
    .range_hits_o(range_hits),
    .pending_o   (pending_rsps),
    .occupancy_o (occ_hint)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Stall the response channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // End a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_indexed_deque_store_top: errors");
      $finish;
    end
  end

  // Idle at random, then hold the transaction until it is taken
  task automatic drive_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic issue_op(input logic [3:0] f, input int pos, input logic [DataW-1:0] v);
    req_t r;
    r.func       = f;
    r.position   = PosW'(pos);
    r.item_value = v;
    drive_req(r);
  endtask

  // Pick a request biased toward growing, shrinking or a plain mix
  function automatic req_t pick_req(input op_mix_e mix);
    req_t r;
    int   k;
    k            = $urandom_range(99);
    r.item_value = $urandom;
    if ($urandom_range(99) < 85) r.position = PosW'($urandom_range(occ_hint));
    else r.position = PosW'($urandom_range(127));
    case (mix)
      GROW_OPS: begin
        if (k < 30) r.func = FN_PUSH_BACK;
        else if (k < 50) r.func = FN_PUSH_FRONT;
        else if (k < 80) r.func = FN_INSERT;
        else if (k < 88) r.func = FN_READ;
        else if (k < 94) r.func = FN_PEEK_BACK;
        else r.func = 4'($urandom_range(15));
      end
      SHRINK_OPS: begin
        if (k < 20) r.func = FN_POP_FRONT;
        else if (k < 40) r.func = FN_POP_BACK;
        else if (k < 70) r.func = FN_REMOVE;
        else if (k < 80) r.func = FN_READ;
        else if (k < 88) r.func = FN_PEEK_FRONT;
        else r.func = 4'($urandom_range(15));
      end
      default: begin
        if (k < 95) r.func = 4'($urandom_range(FN_REMOVE));
        else if (k < 97) r.func = FN_CLEAR;
        else r.func = 4'($urandom_range(FnUnusedHigh, FnUnusedLow));
      end
    endcase
    return r;
  endfunction

  // One idle/stall setting: fill and probe the full store, mixed bursts, drain
  task automatic run_phase(input int idle, input int stall, input int budget);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = sent;
    while (occ_hint < Capacity) drive_req(pick_req(GROW_OPS));
    issue_op(FN_PUSH_BACK, 0, $urandom);
    issue_op(FN_PUSH_FRONT, 0, $urandom);
    issue_op(FN_INSERT, Capacity, $urandom);
    issue_op(FN_INSERT, Capacity + 1, $urandom);
    issue_op(FN_INSERT, $urandom_range(Capacity - 1), $urandom);
    issue_op(FN_READ, Capacity - 1, 0);
    issue_op(FN_READ, Capacity, 0);
    issue_op(FN_REMOVE, Capacity, 0);
    issue_op(FN_PEEK_BACK, 0, 0);
    while (sent - start < budget) begin
      repeat ($urandom_range(40, 5)) drive_req(pick_req(op_mix_e'($urandom_range(2))));
    end
    while (occ_hint != 0) drive_req(pick_req(SHRINK_OPS));
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, both extremes of the value, edges of the index
    issue_op(FN_POP_FRONT, 0, 0);
    issue_op(FN_POP_BACK, 0, 0);
    issue_op(FN_PEEK_FRONT, 0, 0);
    issue_op(FN_PEEK_BACK, 0, 0);
    issue_op(FN_READ, 0, 0);
    issue_op(FN_REMOVE, 0, 0);
    issue_op(FN_INSERT, 1, 32'h1234_5678);
    issue_op(FN_INSERT, 0, 32'h7fff_ffff);
    issue_op(FN_PUSH_FRONT, 0, 32'h8000_0000);
    issue_op(FN_PUSH_BACK, 0, 32'hffff_ffff);
    issue_op(FN_INSERT, 3, 32'h0000_0000);
    issue_op(FN_INSERT, 2, 32'h0000_0001);
    issue_op(FN_READ, 4, 0);
    issue_op(FN_READ, 127, 0);
    issue_op(FN_READ, 5, 0);
    issue_op(FN_REMOVE, 5, 0);
    issue_op(FN_REMOVE, 2, 32'hffff_ffff);
    issue_op(FN_PEEK_FRONT, 0, 0);
    issue_op(FN_PEEK_BACK, 0, 0);
    issue_op(FN_POP_BACK, 0, 0);
    issue_op(FN_POP_FRONT, 0, 0);
    issue_op(FnUnusedHigh, 127, 32'hffff_ffff);
    issue_op(FnUnusedLow, 0, 32'h5555_aaaa);
    issue_op(FN_CLEAR, 0, 0);
    issue_op(FN_CLEAR, 0, 0);

    run_phase(0, 0, PhaseItems);
    run_phase(62, 0, PhaseItems);
    run_phase(0, 62, PhaseItems);
    run_phase(15, 15, PhaseItems);

    // Drain every outstanding response, then let the pipeline settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests over four idle/stall phases; %0d responses checked,",
             sent, checked);
    $display("  %0d with full status and %0d with empty/out-of-range status",
             full_hits, range_hits);
    if (fail_count == 0) begin
      $display("tb_indexed_deque_store_top: clean");
    end else begin
      $display("tb_indexed_deque_store_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/idq_pkg.sv
hw/rtl/idq_cell.sv
hw/rtl/indexed_deque_store_top.sv
dv/idq_store_checker.sv
dv/tb_indexed_deque_store_top.sv
